### design/scan_sector_median_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan sector median core
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SCAN_SECTOR_MEDIAN_CORE_ASSERT_SVH
`define SCAN_SECTOR_MEDIAN_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside of reset.
`define SSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// A condition that must be followed by another one in the next cycle.
`define SSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SSM_ASSERT(lbl, clk, rstn, prop)
`define SSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// Scan sector median package
// Shared constants, types and helpers of the scan sector median core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  localparam int unsigned HALF_WINDOW = 3;
  localparam int unsigned MAX_SCAN    = 4096;
  localparam int unsigned WIN_DEPTH   = 2 * HALF_WINDOW + 1;
  localparam int unsigned IDX_W       = $clog2(WIN_DEPTH);
  localparam int unsigned CNT_W       = $clog2(WIN_DEPTH + 1);
  localparam int unsigned POS_W       = $clog2(MAX_SCAN);
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned NUM_SEC     = 3;

  localparam logic [DATA_W-1:0] NO_WALL_MM = DATA_W'(10000);

  typedef logic [1:0] sec_t;
  localparam sec_t SEC_FRONT = 2'd0;
  localparam sec_t SEC_LEFT  = 2'd1;
  localparam sec_t SEC_RIGHT = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SCAN_LEN = 2'd0;
  localparam reg_idx_t REG_MIN_MM   = 2'd1;
  localparam reg_idx_t REG_MAX_MM   = 2'd2;

  typedef logic [NUM_SEC-1:0][CNT_W-1:0] cnt_vec_t;

  // Write request from the sample capture to the sector stores.
  typedef struct packed {
    logic [NUM_SEC-1:0]            we;
    logic [NUM_SEC-1:0][IDX_W-1:0] addr;
    logic [DATA_W-1:0]             data;
  } wr_req_t;

  // Read request from the median sequencer to the sector stores.
  typedef struct packed {
    sec_t             sec;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } rd_req_t;

  // A length of zero counts as one; anything above the maximum is clamped.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_SCAN)) begin
      res = LEN_W'(MAX_SCAN);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/ssm_store.sv
// ----------------------------------------------------------------------------
// Sector sample store
// Three small memories of kept samples, one write port per sector and two
// registered read ports into the sector chosen by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_store (
  input  logic                             clk_i,
  input  ssm_pkg::wr_req_t                 wr_i,
  input  ssm_pkg::rd_req_t                 rd_i,
  output logic [ssm_pkg::DATA_W-1:0]       rd_a_o,
  output logic [ssm_pkg::DATA_W-1:0]       rd_b_o
);
  import ssm_pkg::*;

  logic [DATA_W-1:0] mem_q [NUM_SEC][WIN_DEPTH];
  logic [DATA_W-1:0] rd_a_q;
  logic [DATA_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_SEC; s++) begin
      if (wr_i.we[s]) begin
        mem_q[s][wr_i.addr[s]] <= wr_i.data;
      end
    end
    unique case (rd_i.sec)
      SEC_FRONT: begin
        rd_a_q <= mem_q[0][rd_i.addr_a];
        rd_b_q <= mem_q[0][rd_i.addr_b];
      end
      SEC_LEFT: begin
        rd_a_q <= mem_q[1][rd_i.addr_a];
        rd_b_q <= mem_q[1][rd_i.addr_b];
      end
      SEC_RIGHT: begin
        rd_a_q <= mem_q[2][rd_i.addr_a];
        rd_b_q <= mem_q[2][rd_i.addr_b];
      end
      default: begin
      end
    endcase
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

### design/ssm_window.sv
// ----------------------------------------------------------------------------
// Sample capture
// Tracks the position in the scan, decides which sector windows a sample
// falls into and issues writes of in-band samples to the sector stores.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scan_sector_median_core_assert.svh"

module ssm_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [ssm_pkg::DATA_W-1:0] range_mm_i,
  input  logic [ssm_pkg::LEN_W-1:0]  len_i,
  input  logic [ssm_pkg::DATA_W-1:0] min_mm_i,
  input  logic [ssm_pkg::DATA_W-1:0] max_mm_i,
  output ssm_pkg::wr_req_t           wr_o,
  output logic                       last_o,
  output ssm_pkg::cnt_vec_t          cnt_next_o
);
  import ssm_pkg::*;

  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_d;
  cnt_vec_t         cnt_q;
  cnt_vec_t         cnt_d;

  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W:0]   len_x3;
  logic [LEN_W-1:0] centre [NUM_SEC];
  logic [LEN_W-1:0] lo     [NUM_SEC];
  logic [LEN_W-1:0] hi     [NUM_SEC];
  logic             in_band;
  logic             last;

  always_comb begin
    len_m1  = len_i - LEN_W'(1);
    pos_ext = LEN_W'(pos_q);
    len_x3  = {len_i, 1'b0} + {1'b0, len_i};

    centre[0] = len_i >> 1;
    centre[1] = LEN_W'(len_x3 >> 2);
    centre[2] = len_i >> 2;

    in_band = (range_mm_i >= min_mm_i) && (range_mm_i <= max_mm_i);
    last    = pos_ext >= len_m1;

    wr_o.data = range_mm_i;
    for (int s = 0; s < NUM_SEC; s++) begin
      lo[s] = (centre[s] >= LEN_W'(HALF_WINDOW)) ? centre[s] - LEN_W'(HALF_WINDOW) : '0;
      hi[s] = centre[s] + LEN_W'(HALF_WINDOW);
      if (hi[s] > len_m1) begin
        hi[s] = len_m1;
      end
      wr_o.we[s]   = accept_i && in_band && (pos_ext >= lo[s]) && (pos_ext <= hi[s]) &&
                     (cnt_q[s] < CNT_W'(WIN_DEPTH));
      wr_o.addr[s] = cnt_q[s][IDX_W-1:0];
      cnt_d[s]     = cnt_q[s] + CNT_W'(wr_o.we[s]);
    end

    pos_d = last ? '0 : pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cnt_q <= last ? '0 : cnt_d;
    end
  end

  assign last_o     = last;
  assign cnt_next_o = cnt_d;

  `SSM_ASSERT(a_counts_bounded, clk_i, rst_ni, (cnt_q[0] <= CNT_W'(WIN_DEPTH)) && (cnt_q[1] <= CNT_W'(WIN_DEPTH)) && (cnt_q[2] <= CNT_W'(WIN_DEPTH)))
  `SSM_ASSERT_NEXT(a_scan_restart, clk_i, rst_ni, accept_i && last, (pos_q == '0) && (cnt_q == '0))

endmodule

`default_nettype wire

### design/ssm_median.sv
// ----------------------------------------------------------------------------
// Median sequencer
// Finds the upper middle kept sample of each sector with one shared
// comparator: every candidate is ranked against all kept samples in turn.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scan_sector_median_core_assert.svh"

module ssm_median (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  ssm_pkg::cnt_vec_t          cnt_i,
  input  logic [ssm_pkg::DATA_W-1:0] rd_a_i,
  input  logic [ssm_pkg::DATA_W-1:0] rd_b_i,
  output ssm_pkg::rd_req_t           rd_o,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ssm_pkg::DATA_W-1:0] front_o,
  output logic [ssm_pkg::DATA_W-1:0] left_o,
  output logic [ssm_pkg::DATA_W-1:0] right_o
);
  import ssm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_FETCH,
    S_CMP,
    S_ADV
  } state_e;

  state_e                          state_q;
  sec_t                            sec_q;
  logic [IDX_W-1:0]                i_q;
  logic [IDX_W-1:0]                j_q;
  logic [CNT_W-1:0]                lt_q;
  logic [CNT_W-1:0]                le_q;
  logic [CNT_W-1:0]                n_q;
  cnt_vec_t                        cnt_q;
  logic [NUM_SEC-1:0][DATA_W-1:0]  res_q;
  logic                            done_q;

  logic [CNT_W-1:0] lt_d;
  logic [CNT_W-1:0] le_d;
  logic [CNT_W-1:0] rank;
  logic [CNT_W-1:0] n_m1;
  logic             hit;
  logic             last_j;
  logic             last_i;

  // Sample b below a raises the rank floor of a; b at or below a raises its ceiling.
  always_comb begin
    lt_d   = lt_q + CNT_W'(rd_b_i < rd_a_i);
    le_d   = le_q + CNT_W'(rd_b_i <= rd_a_i);
    rank   = n_q >> 1;
    n_m1   = n_q - CNT_W'(1);
    hit    = (lt_d <= rank) && (rank < le_d);
    last_j = CNT_W'(j_q) == n_m1;
    last_i = CNT_W'(i_q) == n_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sec_q   <= SEC_FRONT;
      i_q     <= '0;
      j_q     <= '0;
      lt_q    <= '0;
      le_q    <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (go_i) begin
            cnt_q   <= cnt_i;
            sec_q   <= SEC_FRONT;
            state_q <= S_SEC;
          end
        end
        S_SEC: begin
          n_q  <= cnt_q[sec_q];
          i_q  <= '0;
          j_q  <= '0;
          lt_q <= '0;
          le_q <= '0;
          if (cnt_q[sec_q] == '0) begin
            res_q[sec_q] <= NO_WALL_MM;
            state_q      <= S_ADV;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (last_j) begin
            if (hit || last_i) begin
              res_q[sec_q] <= rd_a_i;
              state_q      <= S_ADV;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              j_q     <= '0;
              lt_q    <= '0;
              le_q    <= '0;
              state_q <= S_FETCH;
            end
          end else begin
            j_q     <= j_q + IDX_W'(1);
            lt_q    <= lt_d;
            le_q    <= le_d;
            state_q <= S_FETCH;
          end
        end
        S_ADV: begin
          if (sec_q == SEC_RIGHT) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            sec_q   <= sec_q + 2'd1;
            state_q <= S_SEC;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rd_o.sec    = sec_q;
  assign rd_o.addr_a = i_q;
  assign rd_o.addr_b = j_q;
  assign busy_o      = state_q != S_IDLE;
  assign done_o      = done_q;
  assign front_o     = res_q[SEC_FRONT];
  assign left_o      = res_q[SEC_LEFT];
  assign right_o     = res_q[SEC_RIGHT];

  `SSM_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
  `SSM_ASSERT(a_idx_in_range, clk_i, rst_ni, (state_q == S_CMP) |-> ((CNT_W'(i_q) < n_q) && (CNT_W'(j_q) < n_q)))
  `SSM_ASSERT(a_rank_found, clk_i, rst_ni, (state_q == S_CMP && last_j && last_i) |-> hit)

endmodule

`default_nettype wire

### design/scan_sector_median_core.sv
// ----------------------------------------------------------------------------
// Scan sector median core
// Three-sector windowed median over one rangefinder scan, with an APB
// register port for the scan length and the accepted range band.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low: a request is accepted
// when start is high and busy is low. The last sample of a scan starts the
// median search, which holds busy high while a single comparator ranks each
// candidate against every kept sample of its sector, a sector keeping up to
// 7 samples. The three medians are then valid on front_mm_o, left_mm_o and
// right_mm_o while done_o is high for exactly one cycle, in the first cycle
// that busy is low again. The receiver cannot stall this output, so it must
// take the request in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_sector_median_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [ssm_pkg::DATA_W-1:0] range_mm_i,
  output logic                       done_o,
  output logic [ssm_pkg::DATA_W-1:0] front_mm_o,
  output logic [ssm_pkg::DATA_W-1:0] left_mm_o,
  output logic [ssm_pkg::DATA_W-1:0] right_mm_o
);
  import ssm_pkg::*;

  logic [LEN_W-1:0]  scan_len_q;
  logic [DATA_W-1:0] min_mm_q;
  logic [DATA_W-1:0] max_mm_q;

  logic              reg_wr;
  reg_idx_t          reg_idx;
  logic [LEN_W-1:0]  len_eff;
  logic              accept;
  logic              last;
  logic              med_busy;
  wr_req_t           wr_req;
  rd_req_t           rd_req;
  cnt_vec_t          cnt_next;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_len_q <= LEN_W'(360);
      min_mm_q   <= DATA_W'(120);
      max_mm_q   <= DATA_W'(3500);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SCAN_LEN: scan_len_q <= pwdata[LEN_W-1:0];
        REG_MIN_MM:   min_mm_q   <= pwdata[DATA_W-1:0];
        REG_MAX_MM:   max_mm_q   <= pwdata[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCAN_LEN: prdata = 32'(scan_len_q);
      REG_MIN_MM:   prdata = 32'(min_mm_q);
      REG_MAX_MM:   prdata = 32'(max_mm_q);
      default:      prdata = '0;
    endcase
  end

  assign len_eff = eff_length(scan_len_q);
  assign busy    = med_busy;
  assign accept  = start && !med_busy;

  ssm_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .range_mm_i (range_mm_i),
    .len_i      (len_eff),
    .min_mm_i   (min_mm_q),
    .max_mm_i   (max_mm_q),
    .wr_o       (wr_req),
    .last_o     (last),
    .cnt_next_o (cnt_next)
  );

  ssm_store u_store (
    .clk_i  (clk_i),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  ssm_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (accept && last),
    .cnt_i   (cnt_next),
    .rd_a_i  (rd_a),
    .rd_b_i  (rd_b),
    .rd_o    (rd_req),
    .busy_o  (med_busy),
    .done_o  (done_o),
    .front_o (front_mm_o),
    .left_o  (left_mm_o),
    .right_o (right_mm_o)
  );

endmodule

`default_nettype wire
